>>> hw/rtl/abs_box_mean_2d_core_defines.svh
// assertion macros for the absolute box mean core
// included by modules that carry assertions; no other dependencies
`ifndef ABS_BOX_MEAN_2D_CORE_DEFINES_SVH
`define ABS_BOX_MEAN_2D_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ABM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ABM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ABM_ASSERT(lbl, clk, rst, prop, msg)
`define ABM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/abm2d_pkg.sv
// shared constants and controller/datapath interface types
// no dependencies
package abm2d_pkg;

   localparam int PATCH_W        = 6;
   localparam int DIM_W          = 11;
   localparam int COORD_W        = 10;
   localparam int MEAN_W         = 24;
   localparam int FRAC_W         = 8;
   localparam int SQ_W           = 2 * PATCH_W;
   localparam int MAX_HEIGHT     = 1024;
   localparam int MAX_PATCH_DEF  = 32;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int PIXEL_BITS_DEF = 16;
   localparam int CSR_AW         = 4;
   localparam int CSR_DW         = 32;

   localparam logic [1:0] REG_PATCH  = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [PATCH_W-1:0] PATCH_RST  = 6'd3;
   localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd1024;
   localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd1024;

   typedef struct packed {
      logic accept;
      logic clr;
      logic div_mod;
      logic upd;
      logic win;
      logic div_mean;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic patch_ok;
      logic clr_last;
      logic div_done;
      logic emit;
      logic out_free;
   } sts_type;

endpackage

>>> hw/rtl/abs_box_mean_2d_core.sv
// absolute box mean core: a new request is taken only once the previous one is finished
// DIV_W = PIXEL_BITS+12+log2(MAX_WIDTH)+10 (48 by default); the shared bit-serial divider
// computes the row slot (row mod patch) and then the mean, one bit per cycle
// the result is registered once the mean division is done; a stalled result holds back the next window
// synchronous reset restores default registers, then a pass over all MAX_WIDTH columns clears column sums
// uses abm2d_pkg, abm2d_ctrl, abm2d_dp
module abs_box_mean_2d_core #(
   parameter int MAX_PATCH  = abm2d_pkg::MAX_PATCH_DEF,
   parameter int MAX_WIDTH  = abm2d_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = abm2d_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [PIXEL_BITS-1:0]       req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [abm2d_pkg::MEAN_W-1:0]       rsp_abs_mean,
   output logic [abm2d_pkg::COORD_W-1:0]      rsp_out_x,
   output logic [abm2d_pkg::COORD_W-1:0]      rsp_out_y,
   output logic                               rsp_last_in_frame,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [abm2d_pkg::CSR_AW-1:0]       paddr,
   input  logic [abm2d_pkg::CSR_DW-1:0]       pwdata,
   output logic [abm2d_pkg::CSR_DW-1:0]       prdata,
   output logic                               pready
);

   localparam int CSR_DW  = abm2d_pkg::CSR_DW;
   localparam int PATCH_W = abm2d_pkg::PATCH_W;
   localparam int DIM_W   = abm2d_pkg::DIM_W;

   logic [PATCH_W-1:0] patch_ff;
   logic [DIM_W-1:0]   width_ff, height_ff;
   logic [1:0]         reg_idx;
   abm2d_pkg::cmd_type cmd;
   abm2d_pkg::sts_type sts;

   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         patch_ff  <= abm2d_pkg::PATCH_RST;
         width_ff  <= abm2d_pkg::WIDTH_RST;
         height_ff <= abm2d_pkg::HEIGHT_RST;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            abm2d_pkg::REG_PATCH:  patch_ff  <= pwdata[PATCH_W-1:0];
            abm2d_pkg::REG_WIDTH:  width_ff  <= pwdata[DIM_W-1:0];
            abm2d_pkg::REG_HEIGHT: height_ff <= pwdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         abm2d_pkg::REG_PATCH:  prdata = CSR_DW'(patch_ff);
         abm2d_pkg::REG_WIDTH:  prdata = CSR_DW'(width_ff);
         abm2d_pkg::REG_HEIGHT: prdata = CSR_DW'(height_ff);
         default:               prdata = '0;
      endcase
   end

   abm2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   abm2d_dp #(
      .MAX_PATCH  (MAX_PATCH),
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .patch_size        (patch_ff),
      .frame_width       (width_ff),
      .frame_height      (height_ff),
      .req_pixel         (req_pixel),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_abs_mean      (rsp_abs_mean),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_last_in_frame (rsp_last_in_frame)
   );

endmodule

>>> hw/rtl/abm2d_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module abm2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/abm2d_div.sv
// restoring divider, one quotient bit per cycle
// uses abs_box_mean_2d_core_defines.svh
`include "abs_box_mean_2d_core_defines.svh"
module abm2d_div #(
   parameter int DVD_W = 50,
   parameter int DVS_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quot,
   output logic [DVS_W-1:0] rem
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] q_ff, q_in;
   logic [DVS_W-1:0] r_ff, r_in;
   logic [DVS_W-1:0] d_ff, d_in;
   logic [DVS_W:0]   r_sh;
   logic [DVS_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      r_sh    = {r_ff, q_ff[DVD_W-1]};
      diff    = r_sh - {1'b0, d_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            r_in = diff[DVS_W-1:0];
            q_in = {q_ff[DVD_W-2:0], 1'b1};
         end else begin
            r_in = r_sh[DVS_W-1:0];
            q_in = {q_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;

   `ABM_ASSERT(a_start_idle, clock, reset, start |-> !busy_ff, "divider restarted while busy")

endmodule

>>> hw/rtl/abm2d_ctrl.sv
// sequencing state machine for the absolute box mean core
// uses abm2d_pkg and abs_box_mean_2d_core_defines.svh
`include "abs_box_mean_2d_core_defines.svh"
module abm2d_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output abm2d_pkg::cmd_type cmd,
   input  abm2d_pkg::sts_type sts
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MODW  = 3'd2;
   localparam logic [2:0] ST_UPD   = 3'd3;
   localparam logic [2:0] ST_WIN   = 3'd4;
   localparam logic [2:0] ST_MEANW = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.patch_ok) begin
                  cmd.div_mod = 1'b1;
                  state_in    = ST_MODW;
               end
            end
         end
         ST_MODW: begin
            if (sts.div_done) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = ST_WIN;
         end
         ST_WIN: begin
            cmd.win = 1'b1;
            if (sts.emit) begin
               cmd.div_mean = 1'b1;
               state_in     = ST_MEANW;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MEANW: begin
            if (sts.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `ABM_ASSERT(a_done_wait, clock, reset, sts.div_done |-> (state_ff == ST_MODW || state_ff == ST_MEANW), "divider finished outside a wait state")
   `ABM_ASSERT(a_load_free, clock, reset, cmd.out_load |-> sts.out_free, "result loaded over a pending one")

endmodule

>>> hw/rtl/abm2d_dp.sv
// datapath: position counters, line store, column and window sums, divider, result register
// uses abm2d_pkg, abm2d_ram, abm2d_div and abs_box_mean_2d_core_defines.svh
`include "abs_box_mean_2d_core_defines.svh"
module abm2d_dp #(
   parameter int MAX_PATCH  = abm2d_pkg::MAX_PATCH_DEF,
   parameter int MAX_WIDTH  = abm2d_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = abm2d_pkg::PIXEL_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  abm2d_pkg::cmd_type                    cmd,
   output abm2d_pkg::sts_type                    sts,
   input  logic [abm2d_pkg::PATCH_W-1:0]         patch_size,
   input  logic [abm2d_pkg::DIM_W-1:0]           frame_width,
   input  logic [abm2d_pkg::DIM_W-1:0]           frame_height,
   input  logic signed [PIXEL_BITS-1:0]          req_pixel,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [abm2d_pkg::MEAN_W-1:0]          rsp_abs_mean,
   output logic [abm2d_pkg::COORD_W-1:0]         rsp_out_x,
   output logic [abm2d_pkg::COORD_W-1:0]         rsp_out_y,
   output logic                                  rsp_last_in_frame
);

   localparam int DIM_W   = abm2d_pkg::DIM_W;
   localparam int COORD_W = abm2d_pkg::COORD_W;
   localparam int MEAN_W  = abm2d_pkg::MEAN_W;
   localparam int SQ_W    = abm2d_pkg::SQ_W;
   localparam int PV_W    = abm2d_pkg::PATCH_W + 1;
   localparam int X_W     = $clog2(MAX_WIDTH);
   localparam int CNT_W   = $clog2(MAX_WIDTH + 1);
   localparam int DW      = (CNT_W > DIM_W) ? CNT_W : DIM_W;
   localparam int CS_W    = PIXEL_BITS + 12;
   localparam int WS_W    = CS_W + X_W + 2;
   localparam int DIV_W   = WS_W + abm2d_pkg::FRAC_W;
   localparam int SLOT_W  = $clog2(MAX_PATCH * MAX_WIDTH);

   logic [X_W-1:0]              col_ff, col_in, x_ff, x_now, clr_ff;
   logic [COORD_W-1:0]          row_ff, row_in, y_ff, y_now;
   logic [DW-1:0]               w_eff, xn;
   logic [DIM_W-1:0]            h_eff, yt, yn;
   logic signed [PIXEL_BITS-1:0] px_ff;
   logic signed [CS_W-1:0]      ccur_ff, newcol, cs_rd;
   logic signed [WS_W-1:0]      wsum_ff, wsum_in;
   logic [WS_W-1:0]             mag;
   logic [PIXEL_BITS-1:0]       row_rd;
   logic [CS_W-1:0]             cs_rd_raw;
   logic [SLOT_W-1:0]           slot;
   logic [X_W-1:0]              cs_raddr, cs_waddr;
   logic [CS_W-1:0]             cs_wdata;
   logic                        x_ge_p, y_ge_p;
   logic [DIV_W-1:0]            dvd, quot;
   logic [SQ_W-1:0]             dvs, rem;
   logic                        div_done;
   logic                        rsp_valid_ff;
   logic [MEAN_W-1:0]           mean_ff, mean_sat;
   logic [COORD_W-1:0]          ox_ff, oy_ff;
   logic                        last_ff;
   logic [DW-1:0]               ox_full;
   logic [DIM_W-1:0]            oy_full;

   // effective frame size
   always_comb begin
      if (frame_width == '0) begin
         w_eff = DW'(1);
      end else if (DW'(frame_width) > DW'(MAX_WIDTH)) begin
         w_eff = DW'(MAX_WIDTH);
      end else begin
         w_eff = DW'(frame_width);
      end
      if (frame_height == '0) begin
         h_eff = DIM_W'(1);
      end else if (frame_height > DIM_W'(abm2d_pkg::MAX_HEIGHT)) begin
         h_eff = DIM_W'(abm2d_pkg::MAX_HEIGHT);
      end else begin
         h_eff = frame_height;
      end
   end

   // position of this pixel and of the next one
   always_comb begin
      if (DW'(col_ff) >= w_eff) begin
         x_now = '0;
         yt    = DIM_W'(row_ff) + 1'b1;
      end else begin
         x_now = col_ff;
         yt    = DIM_W'(row_ff);
      end
      y_now = (yt >= h_eff) ? '0 : yt[COORD_W-1:0];
      xn    = DW'(x_now) + 1'b1;
      yn    = DIM_W'(y_now) + 1'b1;
      if (xn >= w_eff) begin
         col_in = '0;
         row_in = (yn >= h_eff) ? '0 : yn[COORD_W-1:0];
      end else begin
         col_in = xn[X_W-1:0];
         row_in = y_now;
      end
   end

   assign x_ge_p = DW'(x_ff) >= DW'(patch_size);
   assign y_ge_p = DIM_W'(y_ff) >= DIM_W'(patch_size);

   // line store slot from the row remainder
   assign slot = SLOT_W'(SLOT_W'(rem) * SLOT_W'(MAX_WIDTH)) + SLOT_W'(x_ff);

   abm2d_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_PATCH * MAX_WIDTH)
   ) u_row_ram (
      .clock (clock),
      .we    (cmd.upd),
      .waddr (slot),
      .wdata (px_ff),
      .raddr (slot),
      .rdata (row_rd)
   );

   assign cs_raddr = cmd.upd ? X_W'(DW'(x_ff) - DW'(patch_size)) : x_ff;
   assign cs_waddr = cmd.clr ? clr_ff : x_ff;
   assign cs_wdata = cmd.clr ? '0 : newcol;

   abm2d_ram #(
      .WIDTH (CS_W),
      .DEPTH (MAX_WIDTH)
   ) u_col_ram (
      .clock (clock),
      .we    (cmd.clr | cmd.upd),
      .waddr (cs_waddr),
      .wdata (cs_wdata),
      .raddr (cs_raddr),
      .rdata (cs_rd_raw)
   );

   assign cs_rd = $signed(cs_rd_raw);

   always_comb begin
      if (y_ff == '0) begin
         newcol = CS_W'(px_ff);
      end else if (y_ge_p) begin
         newcol = cs_rd + CS_W'(px_ff) - CS_W'($signed(row_rd));
      end else begin
         newcol = cs_rd + CS_W'(px_ff);
      end
      if (x_ff == '0) begin
         wsum_in = WS_W'(ccur_ff);
      end else if (x_ge_p) begin
         wsum_in = wsum_ff + WS_W'(ccur_ff) - WS_W'(cs_rd);
      end else begin
         wsum_in = wsum_ff + WS_W'(ccur_ff);
      end
      mag = wsum_in[WS_W-1] ? WS_W'(-wsum_in) : WS_W'(wsum_in);
   end

   always_comb begin
      if (cmd.div_mod) begin
         dvd = DIV_W'(y_now);
         dvs = SQ_W'(patch_size);
      end else begin
         dvd = {mag, abm2d_pkg::FRAC_W'(0)};
         dvs = SQ_W'(SQ_W'(patch_size) * SQ_W'(patch_size));
      end
   end

   abm2d_div #(
      .DVD_W (DIV_W),
      .DVS_W (SQ_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_mod | cmd.div_mean),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   assign mean_sat = (|quot[DIV_W-1:MEAN_W]) ? '1 : quot[MEAN_W-1:0];
   assign ox_full  = DW'(x_ff) + 1'b1 - DW'(patch_size);
   assign oy_full  = DIM_W'(y_ff) + 1'b1 - DIM_W'(patch_size);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         clr_ff       <= '0;
         wsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (cmd.clr) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.win) begin
            wsum_ff <= wsum_in;
         end
         rsp_valid_ff <= cmd.out_load | (rsp_valid_ff & rsp_stall);
      end
      if (cmd.accept) begin
         x_ff  <= x_now;
         y_ff  <= y_now;
         px_ff <= req_pixel;
      end
      if (cmd.upd) begin
         ccur_ff <= newcol;
      end
      if (cmd.out_load) begin
         mean_ff <= mean_sat;
         ox_ff   <= ox_full[COORD_W-1:0];
         oy_ff   <= oy_full[COORD_W-1:0];
         last_ff <= (DW'(x_ff) + 1'b1 == w_eff) && (DIM_W'(y_ff) + 1'b1 == h_eff);
      end
   end

   always_comb begin
      sts          = '0;
      sts.patch_ok = (patch_size != '0) && (PV_W'(patch_size) <= PV_W'(MAX_PATCH));
      sts.clr_last = (clr_ff == X_W'(MAX_WIDTH - 1));
      sts.div_done = div_done;
      sts.emit     = (DW'(x_ff) + 1'b1 >= DW'(patch_size)) &&
                     (DIM_W'(y_ff) + 1'b1 >= DIM_W'(patch_size));
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_abs_mean      = mean_ff;
   assign rsp_out_x         = ox_ff;
   assign rsp_out_y         = oy_ff;
   assign rsp_last_in_frame = last_ff;

   `ABM_ASSERT_NEXT(a_load_valid, clock, reset, cmd.out_load, rsp_valid_ff, "loaded result not presented")

endmodule

>>> dv/abs_box_mean_2d_checker.sv
`timescale 1ns / 1ps
// scoreboard for the absolute box mean core: tracks csr writes, predicts window means
// from accepted requests and compares them with the results; uses abm2d_pkg
module abs_box_mean_2d_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [15:0]                 req_pixel,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [abm2d_pkg::MEAN_W-1:0]       rsp_abs_mean,
   input  logic [abm2d_pkg::COORD_W-1:0]      rsp_out_x,
   input  logic [abm2d_pkg::COORD_W-1:0]      rsp_out_y,
   input  logic                               rsp_last_in_frame,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [abm2d_pkg::CSR_AW-1:0]       paddr,
   input  logic [abm2d_pkg::CSR_DW-1:0]       pwdata,
   input  logic                               pready,
   output int                                 errors,
   output int                                 pending
);

   localparam int MEAN_W     = abm2d_pkg::MEAN_W;
   localparam int COORD_W    = abm2d_pkg::COORD_W;
   localparam int PATCH_W    = abm2d_pkg::PATCH_W;
   localparam int DIM_W      = abm2d_pkg::DIM_W;
   localparam int CSR_AW     = abm2d_pkg::CSR_AW;
   localparam int MAX_HEIGHT = abm2d_pkg::MAX_HEIGHT;
   localparam int LINE_MAX   = 1024;
   localparam int PATCH_MAX  = 32;

   typedef struct packed {
      logic [MEAN_W-1:0]  abs_mean;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               last_in_frame;
   } window_result_type;

   window_result_type mean_queue[$];

   logic [PATCH_W-1:0] cfg_patch;
   logic [DIM_W-1:0]   cfg_width;
   logic [DIM_W-1:0]   cfg_height;

   logic signed [15:0] line_buf[PATCH_MAX*LINE_MAX] = '{default: '0};
   longint             col_acc[LINE_MAX];
   longint             win_acc;
   int unsigned        col_pos;
   int unsigned        row_pos;
   int                 err_count = 0;

   assign pending = mean_queue.size();
   assign errors  = err_count;

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      err_count++;
   endtask

   task automatic predict_window(input logic signed [15:0] px);
      int unsigned w, h, p, x, y, slot;
      longint unsigned mag, mean;
      window_result_type r;
      w = clamp_dim(cfg_width, LINE_MAX);
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      p = cfg_patch;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      x = col_pos;
      y = row_pos;
      if (p >= 1 && p <= PATCH_MAX) begin
         slot = (y % p) * LINE_MAX + x;
         if (y == 0) col_acc[x] = px;
         else if (y >= p) col_acc[x] += longint'(px) - longint'(line_buf[slot]);
         else col_acc[x] += px;
         line_buf[slot] = px;
         if (x == 0) win_acc = col_acc[0];
         else if (x >= p) win_acc += col_acc[x] - col_acc[x-p];
         else win_acc += col_acc[x];
         if (x + 1 >= p && y + 1 >= p) begin
            mag = win_acc < 0 ? -win_acc : win_acc;
            mean = (mag * 256) / (p * p);
            if (mean > 64'hFFFFFF) mean = 64'hFFFFFF;
            r.abs_mean = mean[MEAN_W-1:0];
            r.out_x = COORD_W'(x + 1 - p);
            r.out_y = COORD_W'(y + 1 - p);
            r.last_in_frame = (x + 1 == w && y + 1 == h);
            mean_queue.push_back(r);
         end
      end
      col_pos = x + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = y + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   always @(posedge clock) begin
      window_result_type e;
      if (reset) begin
         cfg_patch = abm2d_pkg::PATCH_RST;
         cfg_width = abm2d_pkg::WIDTH_RST;
         cfg_height = abm2d_pkg::HEIGHT_RST;
         foreach (col_acc[i]) col_acc[i] = 0;
         win_acc = 0;
         col_pos = 0;
         row_pos = 0;
         mean_queue.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_AW-1:2])
               abm2d_pkg::REG_PATCH:  cfg_patch = pwdata[PATCH_W-1:0];
               abm2d_pkg::REG_WIDTH:  cfg_width = pwdata[DIM_W-1:0];
               abm2d_pkg::REG_HEIGHT: cfg_height = pwdata[DIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (mean_queue.size() == 0) begin
               report("result with no request behind it");
            end else begin
               e = mean_queue.pop_front();
               if (rsp_abs_mean !== e.abs_mean)
                  report($sformatf("abs_mean %0d, want %0d", rsp_abs_mean, e.abs_mean));
               if (rsp_out_x !== e.out_x)
                  report($sformatf("out_x %0d, want %0d", rsp_out_x, e.out_x));
               if (rsp_out_y !== e.out_y)
                  report($sformatf("out_y %0d, want %0d", rsp_out_y, e.out_y));
               if (rsp_last_in_frame !== e.last_in_frame)
                  report($sformatf("last_in_frame %0b, want %0b",
                                   rsp_last_in_frame, e.last_in_frame));
            end
         end
         if (req_valid && !req_stall) predict_window(req_pixel);
      end
   end
endmodule

>>> dv/tb_abs_box_mean_2d_core.sv
`timescale 1ns / 1ps
// top of the absolute box mean core testbench: clock, reset, csr writes and pixel frames
// depends on abm2d_pkg, abs_box_mean_2d_core and abs_box_mean_2d_checker
module tb_abs_box_mean_2d_core;

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_valid = 0;
   logic                                req_stall;
   logic signed [15:0]                  req_pixel = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 0;
   logic [abm2d_pkg::MEAN_W-1:0]        rsp_abs_mean;
   logic [abm2d_pkg::COORD_W-1:0]       rsp_out_x;
   logic [abm2d_pkg::COORD_W-1:0]       rsp_out_y;
   logic                                rsp_last_in_frame;
   logic                                psel = 0;
   logic                                penable = 0;
   logic                                pwrite = 0;
   logic [abm2d_pkg::CSR_AW-1:0]        paddr = '0;
   logic [abm2d_pkg::CSR_DW-1:0]        pwdata = '0;
   logic [abm2d_pkg::CSR_DW-1:0]        prdata;
   logic                                pready;

   int   errors;
   int   pending;
   logic idle_on = 0;
   logic want_hold = 0;
   int   hold_left = 0;
   int   burst_left = 0;
   int   random_sent = 0;

   always #6 clock = ~clock;

   abs_box_mean_2d_core dut (.*);

   abs_box_mean_2d_checker chk (.*);

   // receiver: random stall bursts plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (want_hold) begin
         rsp_stall <= 1;
         hold_left <= 800;
      end else if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left <= hold_left - 1;
      end else if (burst_left > 0) begin
         rsp_stall <= 1;
         burst_left <= burst_left - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1;
         burst_left <= $urandom_range(0, 12);
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input int unsigned val);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic send_pixel(input logic [15:0] v);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1;
      req_pixel <= v;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [15:0] pick_pixel();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 64)) - 32);
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      endcase
   endfunction

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // mode 0 random pixels, 1 all most negative, 2 all most positive
   task automatic run_frames(input int unsigned p, input int unsigned w, input int unsigned h,
                             input int unsigned frames, input int mode);
      int unsigned n;
      drain();
      csr_write(abm2d_pkg::REG_PATCH, p);
      csr_write(abm2d_pkg::REG_WIDTH, w);
      csr_write(abm2d_pkg::REG_HEIGHT, h);
      n = clamp_dim(w, 1024) * clamp_dim(h, abm2d_pkg::MAX_HEIGHT) * frames;
      repeat (n) begin
         case (mode)
            1: send_pixel(16'h8000);
            2: send_pixel(16'h7fff);
            default: send_pixel(pick_pixel());
         endcase
      end
   endtask

   initial begin
      int unsigned p, w, h, f;
      repeat (7) @(posedge clock);
      reset <= 0;
      // column sums are cleared after reset
      repeat (1124) @(posedge clock);
      // reset settings, a few pixels of the first row
      repeat (6) send_pixel(pick_pixel());
      drain();
      csr_write(abm2d_pkg::REG_HEIGHT, 1024);
      // frame width and height written while the patch size is still the reset value
      csr_write(abm2d_pkg::REG_WIDTH, 4);
      csr_write(abm2d_pkg::REG_HEIGHT, 1024);
      run_frames(2, 2, 2, 1, 1);
      run_frames(2, 2, 2, 1, 2);
      run_frames(1, 3, 2, 1, 0);
      run_frames(5, 3, 3, 1, 0);
      run_frames(0, 0, 0, 3, 0);
      run_frames(3, 4, 3, 1, 0);
      idle_on <= 1;
      run_frames(63, 3, 2, 1, 0);
      run_frames(32, 32, 32, 1, 0);
      run_frames(2, 5, 4, 1, 0);
      // long receiver hold-off while requests keep coming
      drain();
      csr_write(abm2d_pkg::REG_PATCH, 1);
      csr_write(abm2d_pkg::REG_WIDTH, 8);
      csr_write(abm2d_pkg::REG_HEIGHT, 8);
      want_hold <= 1;
      @(posedge clock);
      want_hold <= 0;
      repeat (64) send_pixel(pick_pixel());
      while (random_sent < 350) begin
         idle_on <= (random_sent <= 250) && ($urandom_range(0, 3) != 0);
         p = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 8);
         f = $urandom_range(1, 2);
         run_frames(p, w, h, f, 0);
         random_sent += w * h * f;
      end
      drain();
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
